// File: design/tllp_pkg.sv
// Shared constants, register codes and the arctangent table of the leg levelling core.
package tllp_pkg;

  // Default sizes handed to the top level.
  localparam int RANGE_BITS_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  // CORDIC settings: iteration count and accumulator width (degrees, 16 fraction bits).
  localparam int CORDIC_STEPS = 18;
  localparam int Z_W          = 24;
  localparam int ITER_W       = 5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PWM_LOW     = 2'd0,
    REG_PWM_HIGH    = 2'd1,
    REG_REVERSE     = 2'd2,
    REG_LINK_LENGTH = 2'd3
  } reg_index_t;

  // Register values after reset.
  localparam logic [11:0] PWM_LOW_RESET     = 12'd896;
  localparam logic [11:0] PWM_HIGH_RESET    = 12'd2080;
  localparam logic [3:0]  REVERSE_RESET     = 4'd6;
  localparam logic [15:0] LINK_LENGTH_RESET = 16'd762;

  // atan(2^-i) in degrees with 16 fractional bits.
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 24'sd2949120;
      5'd1:    v = 24'sd1740967;
      5'd2:    v = 24'sd919879;
      5'd3:    v = 24'sd466945;
      5'd4:    v = 24'sd234379;
      5'd5:    v = 24'sd117304;
      5'd6:    v = 24'sd58666;
      5'd7:    v = 24'sd29335;
      5'd8:    v = 24'sd14668;
      5'd9:    v = 24'sd7334;
      5'd10:   v = 24'sd3667;
      5'd11:   v = 24'sd1833;
      5'd12:   v = 24'sd917;
      5'd13:   v = 24'sd458;
      5'd14:   v = 24'sd229;
      5'd15:   v = 24'sd115;
      5'd16:   v = 24'sd57;
      5'd17:   v = 24'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/tllp_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle in degrees (Q16).
module tllp_cordic #(
  parameter int CW = 36
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [CW-1:0]               x0,
  input  logic signed [CW-1:0]               y0,
  output logic                               done,
  output logic signed [tllp_pkg::Z_W-1:0]    z
);

  logic signed [CW-1:0]            x;
  logic signed [CW-1:0]            y;
  logic [tllp_pkg::ITER_W-1:0]     iter;
  logic                            busy;
  logic signed [CW-1:0]            xs;
  logic signed [CW-1:0]            ys;

  // Floor shifts of the current vector.
  assign xs = x >>> iter;
  assign ys = y >>> iter;

  // Rotation towards the x axis, accumulating the table angle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= x0;
        y    <= y0;
        z    <= '0;
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tllp_pkg::atan_q16(iter);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tllp_pkg::atan_q16(iter);
        end
        if (iter == tllp_pkg::ITER_W'(tllp_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

endmodule

// File: design/terrain_leg_leveling_pwm_core.sv
// Sequence: a tick with all legs reported gives four results, computed one leg after another by
// the CORDIC, ANGLE_FRAC_BITS+6 multiply steps, ANGLE_FRAC_BITS+18 divide steps and the sequencing
// states; the next leg starts only once the previous result is taken. A leg that needs no
// arctangent skips the CORDIC. Results wait until taken.
// Throughput: one request at a time; a new request is taken once the last result has gone.
// Reset (synchronous, active high) clears all reported ranges and restores register defaults.
module terrain_leg_leveling_pwm_core #(
  parameter int RANGE_BITS      = tllp_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = tllp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // leg [1:0], range [17:2], zero fill above
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // leg_res [1:0], pwm_us [13:2], zero fill above
  output logic        m_tuser,   // is_reference
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int R     = RANGE_BITS;
  localparam int PLW   = R + 2;
  localparam int DW    = R + 3;
  localparam int AGW   = F + 9;
  localparam int AW    = F + 6;
  localparam int PW    = AW + 12;
  localparam int RW    = F + 7;
  localparam int SH    = 16 - F;
  localparam int CW    = ((R + 19 > 34) ? R + 19 : 34) + 2;
  localparam int CNT_W = $clog2(PW + 1);
  localparam int ZW    = tllp_pkg::Z_W;

  localparam logic signed [AGW-1:0] THIRTY  = AGW'(30 << F);
  localparam logic [RW-1:0]         DIVISOR = RW'(60 << F);
  localparam logic signed [ZW:0]    HALF    = (SH == 0) ? '0 : (ZW + 1)'(1 << (SH - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_PREP, S_CORDIC, S_ANGLE, S_MUL, S_DIV, S_FINISH, S_OUT
  } state_t;

  state_t state;

  logic [11:0] pwm_low_us;
  logic [11:0] pwm_high_us;
  logic [3:0]  reverse_mask;
  logic [15:0] link_length;
  logic [R-1:0] leg_range [4];
  logic [3:0]  leg_seen;

  logic [1:0]  ref_leg;
  logic [1:0]  leg_idx;
  logic signed [AGW-1:0] angle;
  logic [11:0] p_start;
  logic        neg;
  logic [AW-1:0] areg;
  logic [PW-1:0] mreg;
  logic [PW-1:0] acc;
  logic [PW-1:0] num;
  logic [RW-1:0] rem;
  logic [12:0]   quo;
  logic [CNT_W-1:0] cnt;

  logic        cordic_start;
  logic        cordic_done;
  logic signed [ZW-1:0] cordic_z;

  // Plane heights, reference choice and height difference of the current leg.
  logic signed [PLW-1:0] plane [4];
  logic [1:0]            ref_comb;
  logic [R-1:0]          low_range;
  logic signed [PLW-1:0] plane_leg;
  logic signed [PLW-1:0] plane_ref;
  logic signed [DW-1:0]  delta;

  always_comb begin
    plane[0] = -$signed({2'b00, leg_range[0]});
    plane[1] = -$signed({2'b00, leg_range[1]});
    plane[2] = -$signed({2'b00, leg_range[2]});
    plane[3] = $signed({2'b00, leg_range[0]}) - $signed({2'b00, leg_range[1]})
             - $signed({2'b00, leg_range[2]});
    ref_comb  = 2'd0;
    low_range = leg_range[0];
    if (leg_range[1] < low_range) begin
      ref_comb  = 2'd1;
      low_range = leg_range[1];
    end
    if (leg_range[2] < low_range) begin
      ref_comb  = 2'd2;
      low_range = leg_range[2];
    end
    if (leg_range[3] < low_range) begin
      ref_comb  = 2'd3;
    end
    case (leg_idx)
      2'd0:    plane_leg = plane[0];
      2'd1:    plane_leg = plane[1];
      2'd2:    plane_leg = plane[2];
      default: plane_leg = plane[3];
    endcase
    case (ref_leg)
      2'd0:    plane_ref = plane[0];
      2'd1:    plane_ref = plane[1];
      2'd2:    plane_ref = plane[2];
      default: plane_ref = plane[3];
    endcase
    delta = DW'(plane_leg) - DW'(plane_ref);
  end

  // CORDIC start vector and rounding of its angle to the working format.
  logic signed [CW-1:0]  cx0;
  logic signed [CW-1:0]  cy0;
  logic signed [ZW:0]    z_add;
  logic signed [ZW:0]    z_round;
  logic signed [AGW-1:0] atan_q;

  assign cx0     = CW'($signed({1'b0, link_length, 16'h0000}));
  assign cy0     = CW'($signed({delta, 16'h0000}));
  assign z_add   = $signed({cordic_z[ZW-1], cordic_z}) + HALF;
  assign z_round = z_add >>> SH;
  assign atan_q  = z_round[AGW-1:0];
  assign cordic_start = (state == S_PREP) && (leg_idx != ref_leg) && (delta > 0);

  tllp_cordic #(
    .CW(CW)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x0    (cx0),
    .y0    (cy0),
    .done  (cordic_done),
    .z     (cordic_z)
  );

  // Clamp, pulse span and operands of the serial multiply.
  logic signed [AGW-1:0] ang_clamp;
  logic signed [AGW-1:0] ang_shift;
  logic [11:0]           ps_c;
  logic [11:0]           pe_c;
  logic signed [12:0]    diff;
  logic signed [12:0]    diff_abs;

  always_comb begin
    ang_clamp = angle;
    if (angle > THIRTY) begin
      ang_clamp = THIRTY;
    end
    if (angle < -THIRTY) begin
      ang_clamp = -THIRTY;
    end
    ang_shift = ang_clamp + THIRTY;
    if (reverse_mask[leg_idx]) begin
      ps_c = pwm_high_us;
      pe_c = pwm_low_us;
    end else begin
      ps_c = pwm_low_us;
      pe_c = pwm_high_us;
    end
    diff     = $signed({1'b0, pe_c}) - $signed({1'b0, ps_c});
    diff_abs = diff[12] ? -diff : diff;
  end

  // One step of the shift-add multiply and of the restoring divide.
  logic [PW-1:0] acc_next;
  logic [RW-1:0] trial;
  logic          qbit;
  logic [RW-1:0] rem_next;

  always_comb begin
    acc_next = areg[0] ? acc + mreg : acc;
    trial    = {rem[RW-2:0], num[PW-1]};
    qbit     = (trial >= DIVISOR);
    rem_next = qbit ? trial - DIVISOR : trial;
  end

  // Floor correction of the quotient and final pulse width.
  logic signed [13:0] q_s;
  logic signed [13:0] q_f;
  logic signed [13:0] pwm_s;

  always_comb begin
    q_s = $signed({1'b0, quo});
    if (neg) begin
      q_f = (rem != '0) ? -q_s - 14'sd1 : -q_s;
    end else begin
      q_f = q_s;
    end
    pwm_s = $signed({2'b00, p_start}) + q_f;
  end

  assign s_tready = (state == S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_low_us   <= tllp_pkg::PWM_LOW_RESET;
      pwm_high_us  <= tllp_pkg::PWM_HIGH_RESET;
      reverse_mask <= tllp_pkg::REVERSE_RESET;
      link_length  <= tllp_pkg::LINK_LENGTH_RESET;
    end else if (cfg_we) begin
      case (tllp_pkg::reg_index_t'(cfg_index))
        tllp_pkg::REG_PWM_LOW:     pwm_low_us   <= cfg_data[11:0];
        tllp_pkg::REG_PWM_HIGH:    pwm_high_us  <= cfg_data[11:0];
        tllp_pkg::REG_REVERSE:     reverse_mask <= cfg_data[3:0];
        tllp_pkg::REG_LINK_LENGTH: link_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: range storage, per-leg angle, serial arithmetic and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      leg_seen <= '0;
      m_tvalid <= 1'b0;
      leg_idx  <= '0;
      cnt      <= '0;
      for (int i = 0; i < 4; i++) begin
        leg_range[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (!s_tuser) begin
              leg_range[s_tdata[1:0]] <= R'(s_tdata[17:2]);
              leg_seen[s_tdata[1:0]]  <= 1'b1;
            end else if (&leg_seen) begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          ref_leg <= ref_comb;
          leg_idx <= 2'd0;
          state   <= S_PREP;
        end
        S_PREP: begin
          if (cordic_start) begin
            state <= S_CORDIC;
          end else begin
            angle <= THIRTY;
            state <= S_ANGLE;
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            angle <= THIRTY - atan_q;
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          p_start <= ps_c;
          neg     <= diff[12];
          areg    <= ang_shift[AW-1:0];
          mreg    <= PW'(diff_abs[11:0]);
          acc     <= '0;
          cnt     <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          acc  <= acc_next;
          areg <= areg >> 1;
          mreg <= mreg << 1;
          if (cnt == CNT_W'(AW - 1)) begin
            num   <= acc_next;
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= {quo[11:0], qbit};
          num <= num << 1;
          if (cnt == CNT_W'(PW - 1)) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FINISH: begin
          m_tdata  <= {2'b00, pwm_s[11:0], leg_idx};
          m_tuser  <= (leg_idx == ref_leg);
          m_tlast  <= (leg_idx == 2'd3);
          m_tvalid <= 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (leg_idx == 2'd3) begin
              state <= S_IDLE;
            end else begin
              leg_idx <= leg_idx + 1'b1;
              state   <= S_PREP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
